@@ src/ihtr_pkg.sv @@
package ihtr_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TARGET_TEMP      = 3'd0,
    CFG_PWM_MAX          = 3'd1,
    CFG_PROP_GAIN        = 3'd2,
    CFG_CONTROL_MODE     = 3'd3,
    CFG_STABLE_ERR_LIMIT = 3'd4
  } cfg_index_t;

  localparam logic MODE_PROP = 1'b0;
  localparam logic MODE_PI   = 1'b1;

  // How an item is handled once the gates and the range check are applied.
  typedef enum logic [1:0] {
    KIND_OFF  = 2'd0,
    KIND_BAD  = 2'd1,
    KIND_PROP = 2'd2,
    KIND_PI   = 2'd3
  } kind_t;

  localparam logic [31:0]        PI_PERIOD_MS   = 32'd100;
  localparam logic [31:0]        DT_CAP_MS      = 32'd200;
  localparam logic [31:0]        WINDOW_MS      = 32'd2000;
  localparam logic [15:0]        PI_LIMIT_CAP   = 16'd200;
  localparam logic signed [21:0] PROP_PI_GAIN   = 22'sd20;
  localparam logic signed [17:0] CUTOFF_Q8      = 18'sd256;
  localparam logic signed [16:0] WINDOW_SPAN_Q8 = 17'sd128;
  localparam logic signed [16:0] TEMP_LOW_Q8    = -17'sd10240;
  localparam logic signed [16:0] TEMP_HIGH_Q8   = 17'sd15360;
  localparam logic signed [15:0] WIN_LOW_RESET  = 16'sd25600;
  localparam logic signed [15:0] WIN_HIGH_RESET = -16'sd25600;

  localparam logic [5:0]  TARGET_RESET = 6'd40;
  localparam logic [15:0] PWM_MAX_RESET = 16'd200;
  localparam logic [15:0] PROP_GAIN_RESET = 16'd256;
  localparam logic        MODE_RESET = MODE_PI;
  localparam logic [11:0] ERR_LIMIT_RESET = 12'd256;

  // Division of err * dt by 500 is a multiply by a scaled reciprocal of
  // 500 / dt followed by a right shift.
  localparam int          DT_DIV      = 500;
  localparam int          RECIP_SHIFT = 25;
  localparam int          DT_SPAN     = 100;
  localparam longint      RECIP_ROUND_L =
    ((longint'(DT_DIV - 1) << RECIP_SHIFT) + longint'(DT_DIV - 1)) / DT_DIV;
  localparam logic [39:0] RECIP_ROUND = 40'(RECIP_ROUND_L);

  typedef logic [23:0] recip_tab_t [0:DT_SPAN];

  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint     num;
    for (int i = 0; i <= DT_SPAN; i++) begin
      num    = longint'(i + 100) << RECIP_SHIFT;
      tab[i] = 24'((num + longint'(DT_DIV - 1)) / DT_DIV);
    end
    return tab;
  endfunction

  localparam recip_tab_t DT_RECIP = build_recip();

  typedef struct packed {
    logic signed [15:0] temp_q8;
    logic               temp_valid;
    logic [31:0]        now_ms;
    logic               store_writing;
    logic               heat_enable;
  } in_item_t;

  typedef struct packed {
    logic [15:0] heater_pwm;
    logic [23:0] drive_q8;
    logic        temp_settled;
    logic        heater_on;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  target_temp;
    logic [15:0] pwm_max;
    logic [15:0] prop_gain;
    logic        control_mode;
    logic [11:0] stable_err_limit;
  } cfg_t;

  // Timestamps the first stage needs, after any pending update.
  typedef struct packed {
    logic [31:0] last_ms;
    logic [31:0] win_ms;
  } fwd_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] temp;
    logic [31:0]        now;
    logic               stable_err;
    logic               due;
    logic               roll;
    logic               err_le0;
    logic               cutoff;
    logic signed [15:0] step;
    logic signed [21:0] prop;
    logic [15:0]        limit;
    logic [23:0]        drive_p;
  } prep_t;

endpackage

@@ src/ihtr_prep.sv @@
module ihtr_prep (
  input  ihtr_pkg::in_item_t item,
  input  ihtr_pkg::cfg_t     cfg,
  input  ihtr_pkg::fwd_t     fwd,
  output ihtr_pkg::prep_t    prep
);
  import ihtr_pkg::*;

  logic signed [16:0] target_q8;
  logic signed [16:0] temp_x;
  logic signed [16:0] err;
  logic [15:0]        err_abs;
  logic               err_neg;
  logic               in_range;
  kind_t              kind;
  logic [31:0]        el;
  logic [31:0]        wel;
  logic [6:0]         dt_idx;
  logic [23:0]        mult_b;
  logic [38:0]        prod;
  logic [39:0]        qsum;
  logic [14:0]        quot;
  logic [23:0]        dmax;
  logic [23:0]        dprop;
  logic [7:0]         lim_duty;
  logic signed [17:0] cut_level;

  assign target_q8 = signed'({3'b000, cfg.target_temp, 8'h00});
  assign temp_x    = {item.temp_q8[15], item.temp_q8};
  assign err       = target_q8 - temp_x;
  assign err_neg   = err[16];
  assign err_abs   = err_neg ? 16'(-err) : err[15:0];

  assign in_range = item.temp_valid && (temp_x >= TEMP_LOW_Q8) && (temp_x <= TEMP_HIGH_Q8);

  always_comb begin
    if (item.store_writing || !item.heat_enable) begin
      kind = KIND_OFF;
    end else if (!in_range) begin
      kind = KIND_BAD;
    end else if (cfg.control_mode == MODE_PROP) begin
      kind = KIND_PROP;
    end else begin
      kind = KIND_PI;
    end
  end

  assign el  = item.now_ms - fwd.last_ms;
  assign wel = item.now_ms - fwd.win_ms;

  always_comb begin
    if (el >= DT_CAP_MS) begin
      dt_idx = 7'(DT_SPAN);
    end else if (el >= PI_PERIOD_MS) begin
      dt_idx = 7'(el - PI_PERIOD_MS);
    end else begin
      dt_idx = '0;
    end
  end

  // One multiplier serves both modes: |err| times the reciprocal of 500/dt
  // for the PI step, or |err| times the gain for the proportional drive.
  assign mult_b = (cfg.control_mode == MODE_PI) ? DT_RECIP[dt_idx] : {8'h00, cfg.prop_gain};
  assign prod   = 39'(err_abs[14:0]) * 39'(mult_b);

  // A negative error rounds its magnitude up so the signed step floors.
  assign qsum = {1'b0, prod} + (err_neg ? RECIP_ROUND : 40'd0);
  assign quot = qsum[RECIP_SHIFT +: 15];

  assign dmax  = {cfg.pwm_max, 8'h00};
  assign dprop = prod[31:8];

  assign lim_duty  = (cfg.pwm_max < PI_LIMIT_CAP) ? cfg.pwm_max[7:0] : PI_LIMIT_CAP[7:0];
  assign cut_level = 18'(target_q8) + CUTOFF_Q8;

  always_comb begin
    prep.kind       = kind;
    prep.temp       = item.temp_q8;
    prep.now        = item.now_ms;
    prep.stable_err = err_abs <= {4'h0, cfg.stable_err_limit};
    prep.due        = (kind == KIND_PI) && (el >= PI_PERIOD_MS);
    prep.roll       = (kind == KIND_PI) && (wel >= WINDOW_MS);
    prep.err_le0    = err_neg || (err == 17'sd0);
    prep.cutoff     = 18'(temp_x) >= cut_level;
    prep.step       = err_neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    prep.prop       = 22'(err) * PROP_PI_GAIN;
    prep.limit      = {lim_duty, 8'h00};
    if (prep.err_le0) begin
      prep.drive_p = '0;
    end else if (dprop > dmax) begin
      prep.drive_p = dmax;
    end else begin
      prep.drive_p = dprop;
    end
  end

endmodule

@@ src/ihtr_ctrl.sv @@
module ihtr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ihtr_pkg::prep_t     prep,
  output ihtr_pkg::fwd_t      state_ts,
  output ihtr_pkg::out_item_t result
);
  import ihtr_pkg::*;

  logic [31:0]        last_update_r, last_update_nxt;
  logic [31:0]        window_start_r, window_start_nxt;
  logic [15:0]        integral_r, integral_nxt;
  logic [23:0]        drive_hold_r, drive_hold_nxt;
  logic [15:0]        pwm_hold_r, pwm_hold_nxt;
  logic signed [15:0] window_low_r, window_low_nxt;
  logic signed [15:0] window_high_r, window_high_nxt;
  logic               slow_r, slow_nxt;

  logic signed [16:0] cand;
  logic [15:0]        cand_c;
  logic signed [21:0] lim22;
  logic signed [21:0] pc;
  logic signed [21:0] po;
  logic signed [21:0] sum;
  logic               take;
  logic [15:0]        int_pi;
  logic [15:0]        o;
  logic signed [15:0] lo_m;
  logic signed [15:0] hi_m;
  logic signed [16:0] span;
  logic               stable;

  assign lim22 = signed'({6'h00, prep.limit});
  assign cand  = signed'({1'b0, integral_r}) + 17'(prep.step);

  always_comb begin
    if (cand < 17'sd0) begin
      cand_c = '0;
    end else if (cand > signed'({1'b0, prep.limit})) begin
      cand_c = prep.limit;
    end else begin
      cand_c = cand[15:0];
    end
  end

  assign pc   = prep.prop + signed'({6'h00, cand_c});
  assign po   = prep.prop + signed'({6'h00, integral_r});
  assign take = prep.err_le0 || (pc < lim22);
  assign sum  = take ? pc : po;

  always_comb begin
    int_pi = take ? cand_c : integral_r;
    if (sum < 22'sd0) begin
      o = '0;
    end else if (sum > lim22) begin
      o = prep.limit;
    end else begin
      o = sum[15:0];
    end
    if (prep.cutoff) begin
      o      = '0;
      int_pi = '0;
    end
  end

  assign lo_m = (prep.temp < window_low_r) ? prep.temp : window_low_r;
  assign hi_m = (prep.temp > window_high_r) ? prep.temp : window_high_r;
  assign span = {hi_m[15], hi_m} - {lo_m[15], lo_m};

  always_comb begin
    last_update_nxt  = last_update_r;
    window_start_nxt = window_start_r;
    integral_nxt     = integral_r;
    drive_hold_nxt   = drive_hold_r;
    pwm_hold_nxt     = pwm_hold_r;
    window_low_nxt   = window_low_r;
    window_high_nxt  = window_high_r;
    slow_nxt         = slow_r;
    stable           = 1'b0;
    case (prep.kind)
      KIND_OFF: begin
        pwm_hold_nxt = '0;
      end
      KIND_BAD: begin
        pwm_hold_nxt   = '0;
        drive_hold_nxt = '0;
      end
      KIND_PROP: begin
        drive_hold_nxt = prep.drive_p;
        pwm_hold_nxt   = prep.drive_p[23:8];
        stable         = prep.stable_err;
      end
      KIND_PI: begin
        if (prep.due) begin
          last_update_nxt = prep.now;
          integral_nxt    = int_pi;
          drive_hold_nxt  = {8'h00, o};
          pwm_hold_nxt    = {8'h00, o[15:8]};
        end
        window_low_nxt  = lo_m;
        window_high_nxt = hi_m;
        if (prep.roll) begin
          slow_nxt         = span <= WINDOW_SPAN_Q8;
          window_low_nxt   = prep.temp;
          window_high_nxt  = prep.temp;
          window_start_nxt = prep.now;
        end
        stable = prep.stable_err && slow_nxt;
      end
      default: begin
        stable = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_update_r  <= '0;
      window_start_r <= '0;
      integral_r     <= '0;
      drive_hold_r   <= '0;
      pwm_hold_r     <= '0;
      window_low_r   <= WIN_LOW_RESET;
      window_high_r  <= WIN_HIGH_RESET;
      slow_r         <= 1'b0;
    end else if (fire) begin
      last_update_r  <= last_update_nxt;
      window_start_r <= window_start_nxt;
      integral_r     <= integral_nxt;
      drive_hold_r   <= drive_hold_nxt;
      pwm_hold_r     <= pwm_hold_nxt;
      window_low_r   <= window_low_nxt;
      window_high_r  <= window_high_nxt;
      slow_r         <= slow_nxt;
    end
  end

  assign state_ts.last_ms = last_update_r;
  assign state_ts.win_ms  = window_start_r;

  assign result.heater_pwm   = pwm_hold_nxt;
  assign result.drive_q8     = drive_hold_nxt;
  assign result.temp_settled = stable;
  assign result.heater_on    = pwm_hold_nxt != 16'h0000;

endmodule

@@ src/imu_heater_temperature_regulator.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_data  (temp, valid, time, gates)
// out_      output     out_valid / out_stall  out_data (duty, drive, stable, on)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; a result passes through
// the input register, the pre-compute register and the result register before
// it is presented.
// The rate is set by the controller state update in the second stage; the
// first stage sees pending timestamp updates by forwarding from the
// pre-compute register.
// Reset (rst_n low at a clock edge) restores the register defaults and the
// controller state at once; there is no clearing pass.
// A stalled output holds its result while the stages behind it keep filling;
// in_stall rises only when all three stages hold an item.
module imu_heater_temperature_regulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ihtr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ihtr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import ihtr_pkg::*;

  // Configuration registers. Writes must arrive only while the block is idle, a
  // rule on the user that the block does not enforce; they can be taken on every cycle.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temp      <= TARGET_RESET;
      cfg_r.pwm_max          <= PWM_MAX_RESET;
      cfg_r.prop_gain        <= PROP_GAIN_RESET;
      cfg_r.control_mode     <= MODE_RESET;
      cfg_r.stable_err_limit <= ERR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_TEMP:      cfg_r.target_temp      <= cfg_data[5:0];
        CFG_PWM_MAX:          cfg_r.pwm_max          <= cfg_data;
        CFG_PROP_GAIN:        cfg_r.prop_gain        <= cfg_data;
        CFG_CONTROL_MODE:     cfg_r.control_mode     <= cfg_data[0];
        CFG_STABLE_ERR_LIMIT: cfg_r.stable_err_limit <= cfg_data[11:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Three-register pipeline. Each stage moves forward when the next one is
  // empty or is itself moving on in the same cycle.
  logic      in_vld_r, in_vld_nxt;
  logic      mid_vld_r, mid_vld_nxt;
  logic      out_vld_r, out_vld_nxt;
  in_item_t  in_item_r;
  prep_t     mid_r;
  out_item_t out_item_r;

  logic      accept;
  logic      a_adv;
  logic      b_adv;
  fwd_t      state_ts;
  fwd_t      fwd_eff;
  prep_t     prep;
  out_item_t result;

  assign b_adv    = mid_vld_r && (!out_vld_r || !out_stall);
  assign a_adv    = in_vld_r && (!mid_vld_r || b_adv);
  assign in_stall = in_vld_r && !a_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = accept ? 1'b1 : (a_adv ? 1'b0 : in_vld_r);
    mid_vld_nxt = a_adv ? 1'b1 : (b_adv ? 1'b0 : mid_vld_r);
    out_vld_nxt = b_adv ? 1'b1 : (!out_stall ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      mid_vld_r <= mid_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
    if (a_adv) begin
      mid_r <= prep;
    end
    if (b_adv) begin
      out_item_r <= result;
    end
  end

  // The item waiting in the pre-compute register has not yet written its
  // timestamps into the controller state, so the first stage takes them
  // from that register when it is going to.
  always_comb begin
    fwd_eff = state_ts;
    if (mid_vld_r && mid_r.due) begin
      fwd_eff.last_ms = mid_r.now;
    end
    if (mid_vld_r && mid_r.roll) begin
      fwd_eff.win_ms = mid_r.now;
    end
  end

  // First stage: error, gating, elapsed times and the shared multiply.
  ihtr_prep u_prep (
    .item (in_item_r),
    .cfg  (cfg_r),
    .fwd  (fwd_eff),
    .prep (prep)
  );

  // Second stage: PI integration with anti-windup, holds and the stability
  // window; the state commits when the result is registered.
  ihtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (b_adv),
    .prep     (mid_r),
    .state_ts (state_ts),
    .result   (result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // The input side stalls only when every stage is full and the output waits.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && mid_vld_r && out_vld_r && out_stall))
    else $error("input stalled with an empty pipeline stage");

  // A nonzero duty always comes from the drive it was cut from.
  a_duty_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.heater_pwm != 16'h0000))
      |-> (out_data.heater_pwm == out_data.drive_q8[23:8]))
    else $error("heater duty does not match the drive value");

  // A result moved into the output register is presented next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    b_adv |=> (out_valid && (out_data == $past(result))))
    else $error("registered result lost or altered");

endmodule

@@ dv/tb_imu_heater_temperature_regulator.sv @@
`timescale 1ns / 1ps

module tb_imu_heater_temperature_regulator;
  import ihtr_pkg::*;

  // Cycles without any transfer on any channel before the run is declared hung.
  // The longest deliberate output hold-off is STALL_BURST, so this is generous.
  localparam int QUIET_LIMIT = 3000;
  localparam int STALL_BURST = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  imu_heater_temperature_regulator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be offered, and the heater outputs we expect back, oldest first.
  in_item_t  samples_q[$];
  out_item_t heater_results_q[$];
  out_item_t oldest_result;

  // Traffic shaping knobs, set by the stimulus sequence between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_burst_req = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  // Shadow of the configuration registers, updated on every register transfer.
  cfg_t regs;

  // Controller state as the block should hold it.
  logic [31:0] pi_stamp_ms;
  int          integ_acc;
  int          drive_held;
  logic [15:0] duty_held;
  logic [31:0] span_start_ms;
  int          span_low;
  int          span_high;
  bit          span_quiet;

  // Stimulus generator state: a running clock in ms and a temperature walk
  // that hovers around the programmed target.
  logic [31:0] gen_ms = '0;
  int          gen_target = 40;
  int          gen_temp = 10240;

  // Works out the heater output for one accepted sample and advances the
  // controller state exactly as the block should.
  function automatic out_item_t regulate_sample(input in_item_t s);
    out_item_t   r;
    int          temp;
    int          target;
    int          err;
    int          aerr;
    int          limit;
    int          prop;
    int          cand;
    int          n;
    int          o;
    longint      p;
    longint      d;
    longint      mx;
    logic [31:0] el;
    logic [31:0] dt;
    logic [31:0] span_age;
    bit          stable;

    temp = int'(s.temp_q8);
    stable = 1'b0;
    if (s.store_writing || !s.heat_enable) begin
      // Heater forced off; the drive value is left as it was.
      duty_held = '0;
    end else if (!s.temp_valid || temp < int'(TEMP_LOW_Q8) || temp > int'(TEMP_HIGH_Q8)) begin
      duty_held = '0;
      drive_held = 0;
    end else begin
      target = int'(regs.target_temp) * 256;
      err = target - temp;
      aerr = (err < 0) ? -err : err;
      stable = (aerr <= int'(regs.stable_err_limit));
      if (regs.control_mode == MODE_PROP) begin
        p = longint'(err) * longint'(regs.prop_gain);
        d = p >>> 8;
        mx = longint'(regs.pwm_max) * 256;
        if (d < 0) d = 0;
        if (d > mx) d = mx;
        drive_held = int'(d);
        duty_held = 16'(d >> 8);
      end else begin
        el = s.now_ms - pi_stamp_ms;
        if (el >= PI_PERIOD_MS) begin
          dt = (el < DT_CAP_MS) ? el : DT_CAP_MS;
          limit = int'((regs.pwm_max < PI_LIMIT_CAP) ? regs.pwm_max : PI_LIMIT_CAP) * 256;
          prop = int'(PROP_PI_GAIN) * err;
          pi_stamp_ms = s.now_ms;
          // Integration gain of 2 per second: err * dt * 2 / 1000, floored.
          n = err * int'(dt);
          cand = integ_acc + ((n >= 0) ? n / 500 : -((-n + 499) / 500));
          if (cand < 0) cand = 0;
          if (cand > limit) cand = limit;
          // Conditional integration: only wind up while not saturated.
          if (err <= 0 || prop + cand < limit) integ_acc = cand;
          o = prop + integ_acc;
          if (o < 0) o = 0;
          if (o > limit) o = limit;
          if (temp >= target + int'(CUTOFF_Q8)) begin
            o = 0;
            integ_acc = 0;
          end
          drive_held = o;
          duty_held = 16'(o >> 8);
        end
        if (temp < span_low) span_low = temp;
        if (temp > span_high) span_high = temp;
        span_age = s.now_ms - span_start_ms;
        if (span_age >= WINDOW_MS) begin
          span_quiet = (span_high - span_low) <= int'(WINDOW_SPAN_Q8);
          span_low = temp;
          span_high = temp;
          span_start_ms = s.now_ms;
        end
        stable = stable && span_quiet;
      end
    end
    r.heater_pwm = duty_held;
    r.drive_q8 = 24'(drive_held);
    r.temp_settled = stable;
    r.heater_on = (duty_held != '0);
    return r;
  endfunction

  function automatic in_item_t mk_sample(input int temp, input bit ok, input logic [31:0] now,
                                         input bit writing, input bit enable);
    in_item_t s;
    s.temp_q8 = 16'(temp);
    s.temp_valid = ok;
    s.now_ms = now;
    s.store_writing = writing;
    s.heat_enable = enable;
    return s;
  endfunction

  // Random sample: mostly valid readings near the target with realistic time
  // steps, plus some noise, range edges, gate activity and clock jumps.
  function automatic in_item_t next_sample();
    int pick;
    int tgt;
    int t;
    in_item_t s;

    tgt = gen_target * 256;
    pick = $urandom_range(99);
    if (pick < 50) gen_ms += $urandom_range(40);
    else if (pick < 85) gen_ms += $urandom_range(220, 60);
    else if (pick < 97) gen_ms += $urandom_range(2500, 220);
    else gen_ms = $urandom;

    pick = $urandom_range(99);
    if (pick < 55) begin
      gen_temp = gen_temp + int'($urandom_range(48)) - 24;
      if (gen_temp < tgt - 768) gen_temp = tgt - 768;
      if (gen_temp > tgt + 768) gen_temp = tgt + 768;
      t = gen_temp;
    end else if (pick < 75) begin
      // Settled near the target, inside the 0.5 C span, so stability can build up.
      gen_temp = tgt + int'($urandom_range(40)) - 20;
      t = gen_temp;
    end else if (pick < 85) begin
      t = int'($urandom_range(25600)) - 10240;
    end else if (pick < 93) begin
      t = int'($urandom_range(65535));
    end else begin
      case ($urandom_range(5))
        0: t = int'(TEMP_LOW_Q8);
        1: t = int'(TEMP_LOW_Q8) - 1;
        2: t = int'(TEMP_HIGH_Q8);
        3: t = int'(TEMP_HIGH_Q8) + 1;
        4: t = tgt + int'(CUTOFF_Q8);
        default: t = tgt + int'(CUTOFF_Q8) - 1;
      endcase
    end

    s = mk_sample(t, $urandom_range(99) >= 4, gen_ms,
                  $urandom_range(99) < 4, $urandom_range(99) >= 4);
    return s;
  endfunction

  // Input driver. It also tracks register transfers so the shadow
  // configuration is in step with the block, and predicts each accepted sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      regs.target_temp = TARGET_RESET;
      regs.pwm_max = PWM_MAX_RESET;
      regs.prop_gain = PROP_GAIN_RESET;
      regs.control_mode = MODE_RESET;
      regs.stable_err_limit = ERR_LIMIT_RESET;
      pi_stamp_ms = '0;
      integ_acc = 0;
      drive_held = 0;
      duty_held = '0;
      span_start_ms = '0;
      span_low = int'(WIN_LOW_RESET);
      span_high = int'(WIN_HIGH_RESET);
      span_quiet = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_TEMP:      regs.target_temp = cfg_data[5:0];
          CFG_PWM_MAX:          regs.pwm_max = cfg_data;
          CFG_PROP_GAIN:        regs.prop_gain = cfg_data;
          CFG_CONTROL_MODE:     regs.control_mode = cfg_data[0];
          CFG_STABLE_ERR_LIMIT: regs.stable_err_limit = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) heater_results_q.push_back(regulate_sample(in_data));
      // A stalled transfer keeps its payload; otherwise offer the next sample
      // unless this cycle is chosen to be idle.
      if (!in_valid || !in_stall) begin
        if (samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= samples_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result transfer against the oldest prediction
  // and drives the receiver stall, including the long hold-off bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (heater_results_q.size() == 0) begin
          $error("result with no sample waiting: heater_pwm %0d, drive_q8 %0d",
                 out_data.heater_pwm, out_data.drive_q8);
          mismatches++;
        end else begin
          oldest_result = heater_results_q.pop_front();
          if (out_data.heater_pwm !== oldest_result.heater_pwm) begin
            $error("heater_pwm: expected %0d, actual %0d",
                   oldest_result.heater_pwm, out_data.heater_pwm);
            mismatches++;
          end
          if (out_data.drive_q8 !== oldest_result.drive_q8) begin
            $error("drive_q8: expected %0d, actual %0d",
                   oldest_result.drive_q8, out_data.drive_q8);
            mismatches++;
          end
          if (out_data.temp_settled !== oldest_result.temp_settled) begin
            $error("temp_settled: expected %0d, actual %0d",
                   oldest_result.temp_settled, out_data.temp_settled);
            mismatches++;
          end
          if (out_data.heater_on !== oldest_result.heater_on) begin
            $error("heater_on: expected %0d, actual %0d",
                   oldest_result.heater_on, out_data.heater_on);
            mismatches++;
          end
        end
      end
      if (stall_burst_req > 0) begin
        burst_left = stall_burst_req;
        stall_burst_req = 0;
      end else if (burst_left > 0) begin
        burst_left--;
      end
      out_stall <= (burst_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a run where nothing moves for too long is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One register transfer: hold valid until the block takes it.
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: nothing left to offer and every predicted result back, then
  // idle clocks for the pipeline to settle before touching registers.
  task automatic wait_drained();
    while (samples_q.size() != 0 || in_valid || heater_results_q.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input int burst);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stall_burst_req = burst;
    repeat (count) samples_q.push_back(next_sample());
    wait_drained();
  endtask

  task automatic load_regs(input logic [15:0] target, input logic [15:0] max_duty,
                           input logic [15:0] gain, input logic mode,
                           input logic [15:0] err_limit);
    write_reg(CFG_TARGET_TEMP, target);
    write_reg(CFG_PWM_MAX, max_duty);
    write_reg(CFG_PROP_GAIN, gain);
    write_reg(CFG_CONTROL_MODE, 16'(mode));
    write_reg(CFG_STABLE_ERR_LIMIT, err_limit);
    gen_target = int'(target[5:0]);
    gen_temp = gen_target * 256;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples against the reset configuration (PI mode, 40 C target).
    @(negedge clk);
    samples_q.push_back(mk_sample(8960, 1, 32'd100, 0, 1));   // first PI update
    samples_q.push_back(mk_sample(8960, 1, 32'd150, 0, 1));   // update not due yet
    samples_q.push_back(mk_sample(8960, 1, 32'd180, 1, 1));   // store write forces off
    samples_q.push_back(mk_sample(8960, 1, 32'd190, 0, 1));   // held duty and drive disagree
    samples_q.push_back(mk_sample(8960, 1, 32'd400, 0, 0));   // heating disabled
    samples_q.push_back(mk_sample(8960, 0, 32'd500, 0, 1));   // reading not valid
    samples_q.push_back(mk_sample(int'(TEMP_LOW_Q8), 1, 32'd600, 0, 1));
    samples_q.push_back(mk_sample(int'(TEMP_LOW_Q8) - 1, 1, 32'd700, 0, 1));
    samples_q.push_back(mk_sample(int'(TEMP_HIGH_Q8), 1, 32'd800, 0, 1));
    samples_q.push_back(mk_sample(int'(TEMP_HIGH_Q8) + 1, 1, 32'd900, 0, 1));
    samples_q.push_back(mk_sample(32767, 1, 32'd1000, 0, 1));
    samples_q.push_back(mk_sample(-32768, 1, 32'd1050, 0, 1));
    samples_q.push_back(mk_sample(10496, 1, 32'd1100, 0, 1)); // exactly at the cutoff
    samples_q.push_back(mk_sample(10495, 1, 32'd1300, 0, 1)); // just below the cutoff
    // Long gap: capped time step, window rollover and negative error rounding.
    samples_q.push_back(mk_sample(11520, 1, 32'd6300, 0, 1));
    samples_q.push_back(mk_sample(10240, 1, 32'hFFFF_FFC0, 0, 1));
    samples_q.push_back(mk_sample(10250, 1, 32'h0000_0030, 0, 1)); // clock wraps
    samples_q.push_back(mk_sample(10240, 1, 32'hFFFF_FFFF, 1, 0));
    gen_ms = 32'h0000_0100;
    wait_drained();

    // Proportional mode, full gain: both clamps and the rounding of a small
    // negative error, and drive below one duty step.
    load_regs(16'd20, 16'd255, 16'hFFFF, MODE_PROP, 16'd4095);
    @(negedge clk);
    samples_q.push_back(mk_sample(int'(TEMP_LOW_Q8), 1, gen_ms, 0, 1));
    samples_q.push_back(mk_sample(int'(TEMP_HIGH_Q8), 1, gen_ms, 0, 1));
    samples_q.push_back(mk_sample(5121, 1, gen_ms, 0, 1));
    samples_q.push_back(mk_sample(5119, 1, gen_ms, 0, 1));
    samples_q.push_back(mk_sample(5120, 1, gen_ms, 0, 1));
    samples_q.push_back(mk_sample(5000, 0, gen_ms, 0, 1));
    run_phase(80, 0, 0, 0);

    // Default PI settings with a sluggish sender.
    load_regs(16'd40, 16'd200, 16'd256, MODE_PI, 16'd256);
    run_phase(160, 52, 0, 0);

    // Zero output limit and zero error band; gain is unused here.
    load_regs(16'd0, 16'd0, 16'd0, MODE_PI, 16'd0);
    run_phase(60, 0, 52, 0);

    // Receiver holds off for a long stretch while the sender keeps going, so
    // the pipeline fills and pushes back on the input.
    load_regs(16'd60, 16'hFFFF, 16'd1, MODE_PI, 16'd2560);
    run_phase(40, 0, 0, STALL_BURST);
    run_phase(160, 30, 30, 0);

    load_regs(16'd25, 16'hFFFF, 16'd512, MODE_PROP, 16'd128);
    run_phase(80, 30, 30, 0);

    // Target above the documented range is used as written.
    load_regs(16'd63, 16'd150, 16'd256, MODE_PI, 16'd2560);
    run_phase(120, 0, 0, 0);

    repeat (10) @(posedge clk);
    if (heater_results_q.size() != 0) begin
      $error("%0d predicted results never arrived", heater_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ihtr_pkg.sv
src/ihtr_prep.sv
src/ihtr_ctrl.sv
src/imu_heater_temperature_regulator.sv
dv/tb_imu_heater_temperature_regulator.sv
